FILE: src/pgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_pkg
// Formats, derived widths, register indexes and stage payload types for the
// Plummer gravity source pipeline.
// ----------------------------------------------------------------------------
package pgs_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int WORD_WIDTH = 32;
    localparam int GM_WIDTH   = 48;
    localparam int CFG_W      = GM_WIDTH;
    localparam int CFG_IDX_W  = 3;

    // offset magnitude, squared term, softened radius squared
    localparam int MAG_W  = WORD_WIDTH + 1;
    localparam int SQ_W   = 2 * MAG_W - FRAC_BITS;
    localparam int S_W    = SQ_W + 2;
    // square root of s * 2^F, one result bit per stage
    localparam int RAD_W  = ((S_W + FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int RL     = ROOT_W / 2;
    localparam int RH     = ROOT_W - RL;
    localparam int CUBE_W = S_W + ROOT_W - FRAC_BITS;
    // numerator |d| * GM
    localparam int GL     = GM_WIDTH / 2;
    localparam int GH     = GM_WIDTH - GL;
    localparam int NUM_W  = MAG_W + GM_WIDTH;
    // quotient, saturating at 2^63
    localparam int Q_W    = 63;
    localparam int AL     = (Q_W + 1) / 2;
    localparam int AH     = Q_W - AL;
    localparam int TP_W   = Q_W + WORD_WIDTH - 1;
    // a*dt beyond 2^(W+F) always overflows the output
    localparam int TCAP_W = WORD_WIDTH + FRAC_BITS;
    localparam int TL     = TCAP_W / 2;
    localparam int TH     = TCAP_W - TL;
    localparam int MP_W   = TCAP_W + WORD_WIDTH - 1;
    localparam int M_W    = MP_W - FRAC_BITS;

    localparam logic [WORD_WIDTH-1:0] CENTER_RESET = WORD_WIDTH'(64'd5 << FRAC_BITS);
    localparam logic [WORD_WIDTH-2:0] SOFT_RESET   =
        (WORD_WIDTH-1)'((64'd352742 << FRAC_BITS) >> 24);
    localparam logic [WORD_WIDTH-1:0] OUT_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] OUT_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_SOFT     = 3'd2,
        REG_GM       = 3'd3,
        REG_DT       = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                  neg_x;
        logic                  neg_y;
        logic                  last;
        logic [WORD_WIDTH-2:0] dens;
    } t_side;

    typedef struct packed {
        logic [S_W-1:0]    s;
        logic [NUM_W-1:0]  nx;
        logic [NUM_W-1:0]  ny;
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        t_side             side;
    } t_rt;

    typedef struct packed {
        logic [CUBE_W-1:0] c;
        logic              cz;
        logic [NUM_W-1:0]  nx;
        logic [NUM_W-1:0]  ny;
        logic [CUBE_W-1:0] rem_x;
        logic [CUBE_W-1:0] rem_y;
        logic [Q_W-1:0]    q_x;
        logic [Q_W-1:0]    q_y;
        logic              sat_x;
        logic              sat_y;
        t_side             side;
    } t_dv;

endpackage
`default_nettype wire

FILE: src/pgs_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_in_if
// Vertex channel: position, density and last-of-batch flag.
// ----------------------------------------------------------------------------
interface pgs_in_if;
    import pgs_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] pos_x;
    logic signed [WORD_WIDTH-1:0] pos_y;
    logic        [WORD_WIDTH-2:0] density;
    logic                         last_vertex;

    modport source (output valid, output pos_x, output pos_y, output density,
                    output last_vertex, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input density,
                    input last_vertex, output ready);
endinterface
`default_nettype wire

FILE: src/pgs_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgs_out_if
// Result channel: momentum source terms, overflow and last flag.
// ----------------------------------------------------------------------------
interface pgs_out_if;
    import pgs_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] source_x;
    logic signed [WORD_WIDTH-1:0] source_y;
    logic                         overflow;
    logic                         last_result;

    modport source (output valid, output source_x, output source_y, output overflow,
                    output last_result, input ready);
    modport sink   (input valid, input source_x, input source_y, input overflow,
                    input last_result, output ready);
endinterface
`default_nettype wire

FILE: src/plummer_gravity_source_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plummer_gravity_source_core
// Plummer-softened point-mass gravity source terms, one vertex per beat.
// ----------------------------------------------------------------------------
// Usage:
//   i_vtx carries one mesh vertex per beat (pos_x, pos_y, density, last flag);
//   o_src returns one beat per vertex, in order: -a*dt*density for x and y,
//   saturated to the word range, an overflow flag and the copied last flag.
//   Registers (centre, softening squared, GM, dt) are written on i_cfg_*;
//   the user must write them only while no vertex is in flight, since the
//   block does not enforce it; an index beyond the list is ignored.
// Pipeline: 3 front stages, ROOT_W=34 square root stages, 2 cube stages,
//   Q_W=63 divider stages, 5 back stages.
// Throughput: one vertex per cycle unless stalled; every stage holds one
//   vertex and the root and divider pipelines retire one bit per stage.
// Stall: the whole pipe moves on a shared enable; while a result beat waits
//   unaccepted the pipe holds and i_vtx.ready is low; nothing is lost.
// Reset: synchronous; clears all stage valid bits and loads register
//   defaults (centre 5.0, softening 0.145^2, GM 0, dt 0).
// ----------------------------------------------------------------------------
module plummer_gravity_source_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pgs_in_if.sink                         i_vtx,
    pgs_out_if.source                      o_src,
    input  logic                           i_cfg_we,
    input  logic [pgs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pgs_pkg::CFG_W-1:0]      i_cfg_data
);
    import pgs_pkg::*;

    // configuration
    logic [WORD_WIDTH-1:0] r_cx, r_cy;
    logic [WORD_WIDTH-2:0] r_soft, r_dt;
    logic [GM_WIDTH-1:0]   r_gm;

    // valid bits, one per stage
    logic              r_a_v, r_b_v, r_d_v, r_f_v, r_g_v, r_h_v, r_i_v, r_o_v;
    logic [ROOT_W:0]   r_rt_v;
    logic [Q_W:0]      r_dv_v;

    logic w_adv;

    // stage A: offsets
    logic signed [MAG_W-1:0] w_dx, w_dy;
    logic [MAG_W-1:0]        w_mx, w_my;
    logic [MAG_W-1:0]        r_a_mx, r_a_my;
    t_side                   r_a_side;

    // stage B: squares and GM partials
    logic [2*MAG_W-1:0]    w_sqx, w_sqy;
    logic [MAG_W+GL-1:0]   w_nxl, w_nyl;
    logic [MAG_W+GH-1:0]   w_nxh, w_nyh;
    logic [SQ_W-1:0]       r_b_sqx, r_b_sqy;
    logic [MAG_W+GL-1:0]   r_b_nxl, r_b_nyl;
    logic [MAG_W+GH-1:0]   r_b_nxh, r_b_nyh;
    t_side                 r_b_side;

    // stage C and root pipe
    t_rt r_rt [0:ROOT_W];

    // stage D: cube partials
    logic [S_W+RL-1:0] r_d_p0;
    logic [S_W+RH-1:0] r_d_p1;
    logic [NUM_W-1:0]  r_d_nx, r_d_ny;
    t_side             r_d_side;

    // stage E and divider pipe
    logic [S_W+ROOT_W-1:0] w_cube;
    logic [CUBE_W-1:0]     w_c;
    t_dv                   r_dv [0:Q_W];

    // stage F: a*dt partials
    logic [AL+WORD_WIDTH-2:0] r_f_p0x, r_f_p0y;
    logic [AH+WORD_WIDTH-2:0] r_f_p1x, r_f_p1y;
    logic                     r_f_satx, r_f_saty, r_f_cz;
    t_side                    r_f_side;

    // stage G: t, capped
    logic [TP_W-1:0]   w_tx, w_ty;
    logic [TCAP_W-1:0] r_g_tx, r_g_ty;
    logic              r_g_satx, r_g_saty, r_g_cz;
    t_side             r_g_side;

    // stage H: t*density partials
    logic [TL+WORD_WIDTH-2:0] r_h_p0x, r_h_p0y;
    logic [TH+WORD_WIDTH-2:0] r_h_p1x, r_h_p1y;
    logic                     r_h_satx, r_h_saty, r_h_cz;
    t_side                    r_h_side;

    // stage I: magnitudes
    logic [MP_W-1:0] w_mpx, w_mpy;
    logic [M_W-1:0]  r_i_mx, r_i_my;
    logic            r_i_satx, r_i_saty, r_i_cz;
    t_side           r_i_side;

    // output stage
    logic [M_W-1:0]        w_limx, w_limy, w_magx, w_magy;
    logic                  w_zero, w_clipx, w_clipy;
    logic [WORD_WIDTH-1:0] r_o_x, r_o_y;
    logic                  r_o_ovf, r_o_last;

    assign w_adv       = !r_o_v || o_src.ready;
    assign i_vtx.ready = w_adv;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= CENTER_RESET;
            r_cy   <= CENTER_RESET;
            r_soft <= SOFT_RESET;
            r_gm   <= '0;
            r_dt   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X: r_cx   <= i_cfg_data[WORD_WIDTH-1:0];
                REG_CENTER_Y: r_cy   <= i_cfg_data[WORD_WIDTH-1:0];
                REG_SOFT:     r_soft <= i_cfg_data[WORD_WIDTH-2:0];
                REG_GM:       r_gm   <= i_cfg_data[GM_WIDTH-1:0];
                REG_DT:       r_dt   <= i_cfg_data[WORD_WIDTH-2:0];
                default: ;
            endcase
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v  <= 1'b0;
            r_b_v  <= 1'b0;
            r_rt_v <= '0;
            r_d_v  <= 1'b0;
            r_dv_v <= '0;
            r_f_v  <= 1'b0;
            r_g_v  <= 1'b0;
            r_h_v  <= 1'b0;
            r_i_v  <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (w_adv) begin
            r_a_v  <= i_vtx.valid;
            r_b_v  <= r_a_v;
            r_rt_v <= {r_rt_v[ROOT_W-1:0], r_b_v};
            r_d_v  <= r_rt_v[ROOT_W];
            r_dv_v <= {r_dv_v[Q_W-1:0], r_d_v};
            r_f_v  <= r_dv_v[Q_W];
            r_g_v  <= r_f_v;
            r_h_v  <= r_g_v;
            r_i_v  <= r_h_v;
            r_o_v  <= r_i_v;
        end
    end

    // ---------------- front stages ----------------
    assign w_dx = $signed({i_vtx.pos_x[WORD_WIDTH-1], i_vtx.pos_x})
                - $signed({r_cx[WORD_WIDTH-1], r_cx});
    assign w_dy = $signed({i_vtx.pos_y[WORD_WIDTH-1], i_vtx.pos_y})
                - $signed({r_cy[WORD_WIDTH-1], r_cy});
    assign w_mx = w_dx[MAG_W-1] ? MAG_W'(-w_dx) : MAG_W'(w_dx);
    assign w_my = w_dy[MAG_W-1] ? MAG_W'(-w_dy) : MAG_W'(w_dy);

    assign w_sqx = {MAG_W'(0), r_a_mx} * {MAG_W'(0), r_a_mx};
    assign w_sqy = {MAG_W'(0), r_a_my} * {MAG_W'(0), r_a_my};
    assign w_nxl = (MAG_W+GL)'(r_a_mx) * (MAG_W+GL)'(r_gm[GL-1:0]);
    assign w_nyl = (MAG_W+GL)'(r_a_my) * (MAG_W+GL)'(r_gm[GL-1:0]);
    assign w_nxh = (MAG_W+GH)'(r_a_mx) * (MAG_W+GH)'(r_gm[GM_WIDTH-1:GL]);
    assign w_nyh = (MAG_W+GH)'(r_a_my) * (MAG_W+GH)'(r_gm[GM_WIDTH-1:GL]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // A
            r_a_mx          <= w_mx;
            r_a_my          <= w_my;
            r_a_side.neg_x  <= w_dx[MAG_W-1];
            r_a_side.neg_y  <= w_dy[MAG_W-1];
            r_a_side.last   <= i_vtx.last_vertex;
            r_a_side.dens   <= i_vtx.density;
            // B
            r_b_sqx  <= w_sqx[2*MAG_W-1:FRAC_BITS];
            r_b_sqy  <= w_sqy[2*MAG_W-1:FRAC_BITS];
            r_b_nxl  <= w_nxl;
            r_b_nyl  <= w_nyl;
            r_b_nxh  <= w_nxh;
            r_b_nyh  <= w_nyh;
            r_b_side <= r_a_side;
            // C: softened radius squared and full numerators
            r_rt[0].s    <= S_W'(r_b_sqx) + S_W'(r_b_sqy) + S_W'(r_soft);
            r_rt[0].nx   <= NUM_W'(r_b_nxl) + (NUM_W'(r_b_nxh) << GL);
            r_rt[0].ny   <= NUM_W'(r_b_nyl) + (NUM_W'(r_b_nyh) << GL);
            r_rt[0].rem  <= '0;
            r_rt[0].root <= '0;
            r_rt[0].side <= r_b_side;
        end
    end

    // ---------------- square root, one bit per stage ----------------
    for (genvar k = 1; k <= ROOT_W; k++) begin : g_rt
        logic [RAD_W-1:0]  w_rad;
        logic [ROOT_W+1:0] w_rsh, w_trial;
        logic              w_ge;
        t_rt               w_nxt;

        assign w_rad   = RAD_W'({r_rt[k-1].s, {FRAC_BITS{1'b0}}});
        assign w_rsh   = {r_rt[k-1].rem, w_rad[RAD_W-1-2*(k-1) -: 2]};
        assign w_trial = {r_rt[k-1].root, 2'b01};
        assign w_ge    = w_rsh >= w_trial;

        always_comb begin
            w_nxt      = r_rt[k-1];
            w_nxt.rem  = ROOT_W'(w_ge ? w_rsh - w_trial : w_rsh);
            w_nxt.root = {r_rt[k-1].root[ROOT_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rt[k] <= w_nxt;
            end
        end
    end

    // ---------------- cube and divider set-up ----------------
    assign w_cube = (S_W+ROOT_W)'(r_d_p0) + ((S_W+ROOT_W)'(r_d_p1) << RL);
    assign w_c    = w_cube[S_W+ROOT_W-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // D
            r_d_p0   <= (S_W+RL)'(r_rt[ROOT_W].s) * (S_W+RL)'(r_rt[ROOT_W].root[RL-1:0]);
            r_d_p1   <= (S_W+RH)'(r_rt[ROOT_W].s)
                      * (S_W+RH)'(r_rt[ROOT_W].root[ROOT_W-1:RL]);
            r_d_nx   <= r_rt[ROOT_W].nx;
            r_d_ny   <= r_rt[ROOT_W].ny;
            r_d_side <= r_rt[ROOT_W].side;
            // E: a quotient of 2^63 or more saturates
            r_dv[0].c     <= w_c;
            r_dv[0].cz    <= (w_c == '0);
            r_dv[0].nx    <= r_d_nx;
            r_dv[0].ny    <= r_d_ny;
            r_dv[0].rem_x <= CUBE_W'(r_d_nx[NUM_W-1:Q_W]);
            r_dv[0].rem_y <= CUBE_W'(r_d_ny[NUM_W-1:Q_W]);
            r_dv[0].sat_x <= CUBE_W'(r_d_nx[NUM_W-1:Q_W]) >= w_c;
            r_dv[0].sat_y <= CUBE_W'(r_d_ny[NUM_W-1:Q_W]) >= w_c;
            r_dv[0].q_x   <= '0;
            r_dv[0].q_y   <= '0;
            r_dv[0].side  <= r_d_side;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 1; k <= Q_W; k++) begin : g_dv
        logic [CUBE_W:0] w_dshx, w_dshy, w_dc;
        logic            w_gex, w_gey;
        t_dv             w_nxt;

        assign w_dc   = {1'b0, r_dv[k-1].c};
        assign w_dshx = {r_dv[k-1].rem_x, r_dv[k-1].nx[Q_W-k]};
        assign w_dshy = {r_dv[k-1].rem_y, r_dv[k-1].ny[Q_W-k]};
        assign w_gex  = w_dshx >= w_dc;
        assign w_gey  = w_dshy >= w_dc;

        always_comb begin
            w_nxt       = r_dv[k-1];
            w_nxt.rem_x = CUBE_W'(w_gex ? w_dshx - w_dc : w_dshx);
            w_nxt.rem_y = CUBE_W'(w_gey ? w_dshy - w_dc : w_dshy);
            w_nxt.q_x   = {r_dv[k-1].q_x[Q_W-2:0], w_gex};
            w_nxt.q_y   = {r_dv[k-1].q_y[Q_W-2:0], w_gey};
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[k] <= w_nxt;
            end
        end
    end

    // ---------------- back stages ----------------
    assign w_tx = TP_W'(r_f_p0x) + (TP_W'(r_f_p1x) << AL);
    assign w_ty = TP_W'(r_f_p0y) + (TP_W'(r_f_p1y) << AL);
    assign w_mpx = MP_W'(r_h_p0x) + (MP_W'(r_h_p1x) << TL);
    assign w_mpy = MP_W'(r_h_p0y) + (MP_W'(r_h_p1y) << TL);

    // output clamp: a negative term may reach -2^(W-1)
    assign w_limx  = !r_i_side.neg_x ? (M_W'(1) << (WORD_WIDTH-1))
                                     : (M_W'(1) << (WORD_WIDTH-1)) - M_W'(1);
    assign w_limy  = !r_i_side.neg_y ? (M_W'(1) << (WORD_WIDTH-1))
                                     : (M_W'(1) << (WORD_WIDTH-1)) - M_W'(1);
    assign w_zero  = r_i_cz || (r_dt == '0) || (r_i_side.dens == '0);
    assign w_clipx = !w_zero && (r_i_satx || (r_i_mx > w_limx));
    assign w_clipy = !w_zero && (r_i_saty || (r_i_my > w_limy));
    assign w_magx  = w_zero ? '0 : (w_clipx ? w_limx : r_i_mx);
    assign w_magy  = w_zero ? '0 : (w_clipy ? w_limy : r_i_my);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // F
            r_f_p0x  <= (AL+WORD_WIDTH-1)'(r_dv[Q_W].q_x[AL-1:0]) * (AL+WORD_WIDTH-1)'(r_dt);
            r_f_p0y  <= (AL+WORD_WIDTH-1)'(r_dv[Q_W].q_y[AL-1:0]) * (AL+WORD_WIDTH-1)'(r_dt);
            r_f_p1x  <= (AH+WORD_WIDTH-1)'(r_dv[Q_W].q_x[Q_W-1:AL]) * (AH+WORD_WIDTH-1)'(r_dt);
            r_f_p1y  <= (AH+WORD_WIDTH-1)'(r_dv[Q_W].q_y[Q_W-1:AL]) * (AH+WORD_WIDTH-1)'(r_dt);
            r_f_satx <= r_dv[Q_W].sat_x;
            r_f_saty <= r_dv[Q_W].sat_y;
            r_f_cz   <= r_dv[Q_W].cz;
            r_f_side <= r_dv[Q_W].side;
            // G
            r_g_tx   <= w_tx[FRAC_BITS+TCAP_W-1:FRAC_BITS];
            r_g_ty   <= w_ty[FRAC_BITS+TCAP_W-1:FRAC_BITS];
            r_g_satx <= r_f_satx || (|w_tx[TP_W-1:FRAC_BITS+TCAP_W]);
            r_g_saty <= r_f_saty || (|w_ty[TP_W-1:FRAC_BITS+TCAP_W]);
            r_g_cz   <= r_f_cz;
            r_g_side <= r_f_side;
            // H
            r_h_p0x  <= (TL+WORD_WIDTH-1)'(r_g_tx[TL-1:0]) * (TL+WORD_WIDTH-1)'(r_g_side.dens);
            r_h_p0y  <= (TL+WORD_WIDTH-1)'(r_g_ty[TL-1:0]) * (TL+WORD_WIDTH-1)'(r_g_side.dens);
            r_h_p1x  <= (TH+WORD_WIDTH-1)'(r_g_tx[TCAP_W-1:TL])
                      * (TH+WORD_WIDTH-1)'(r_g_side.dens);
            r_h_p1y  <= (TH+WORD_WIDTH-1)'(r_g_ty[TCAP_W-1:TL])
                      * (TH+WORD_WIDTH-1)'(r_g_side.dens);
            r_h_satx <= r_g_satx;
            r_h_saty <= r_g_saty;
            r_h_cz   <= r_g_cz;
            r_h_side <= r_g_side;
            // I
            r_i_mx   <= w_mpx[MP_W-1:FRAC_BITS];
            r_i_my   <= w_mpy[MP_W-1:FRAC_BITS];
            r_i_satx <= r_h_satx;
            r_i_saty <= r_h_saty;
            r_i_cz   <= r_h_cz;
            r_i_side <= r_h_side;
            // output register; the force points at the centre
            r_o_x    <= r_i_side.neg_x ? WORD_WIDTH'(w_magx)
                                       : WORD_WIDTH'(M_W'(0) - w_magx);
            r_o_y    <= r_i_side.neg_y ? WORD_WIDTH'(w_magy)
                                       : WORD_WIDTH'(M_W'(0) - w_magy);
            r_o_ovf  <= w_clipx || w_clipy;
            r_o_last <= r_i_side.last;
        end
    end

    assign o_src.valid       = r_o_v;
    assign o_src.source_x    = r_o_x;
    assign o_src.source_y    = r_o_y;
    assign o_src.overflow    = r_o_ovf;
    assign o_src.last_result = r_o_last;

`ifndef SYNTHESIS
    a_ovf_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o_ovf) |-> (r_o_x == OUT_MAX || r_o_x == OUT_MIN ||
                                r_o_y == OUT_MAX || r_o_y == OUT_MIN))
        else $error("overflow flagged without a saturated term");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_i_v) |=> r_o_v)
        else $error("result lost on the way to the output register");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> (r_o_v && $stable(r_rt_v) && $stable(r_dv_v)))
        else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire
